### sv/pcl_pkg.sv
// shared types, constants and control structs for the per-prefix connection limiter
// no dependencies; used by pcl_ctrl, pcl_datapath and per_prefix_connection_limiter
package pcl_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int QUEUE_DEPTH_DEF   = 256;

    localparam int PREFIX_W = 64;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int PRIO_W   = 17;
    localparam int EXP_W    = 9;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX           = 16'hFFFF;
    localparam logic [COUNT_W-1:0] PRIORITY_FREE_BELOW = 16'd8;
    localparam logic [EXP_W-1:0]   EXPIRED_MAX         = 9'h1FF;

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_ACCEPT = 2'd0;
    localparam cmd_t CMD_CLOSE  = 2'd1;
    localparam cmd_t CMD_TICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_WINDOW   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECTION_LIMIT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_item;    // capture an input transaction
        logic lk_start;     // clear search state and pick the search key
        logic key_from_q;   // search key comes from the queue head
        logic lk_cmp;       // compare one table entry
        logic acc_commit;   // apply an accept
        logic ret_commit;   // retire the queue head
        logic q_wr;         // append a close to the queue
        logic out_load;     // move the result into the output register
    } pcl_ctrl_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic q_empty;
        logic q_full;
        logic q_one;
        logic head_expire;
        logic cmp_hit;
        logic cmp_last;
    } pcl_stat_t;

endpackage

### sv/pcl_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module pcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/pcl_ctrl.sv
// sequencer of the connection limiter: walks each transaction through queue and table steps
// depends on pcl_pkg
module pcl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  pcl_pkg::pcl_stat_t stat,
    output pcl_pkg::pcl_ctrl_t ctrl
);
    import pcl_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_Q_RD   = 4'd2;
    localparam logic [3:0] S_Q_CHK  = 4'd3;
    localparam logic [3:0] S_LK_RD  = 4'd4;
    localparam logic [3:0] S_LK_CMP = 4'd5;
    localparam logic [3:0] S_LK_END = 4'd6;
    localparam logic [3:0] S_Q_WR   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        ctrl         = '0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctrl.load_item = 1'b1;
                    state_next     = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.cmd)
                    CMD_ACCEPT: begin
                        ctrl.lk_start = 1'b1;
                        state_next    = S_LK_RD;
                    end
                    CMD_CLOSE: state_next = stat.q_full ? S_Q_RD : S_Q_WR;
                    CMD_TICK:  state_next = stat.q_empty ? S_DONE : S_Q_RD;
                    default:   state_next = S_DONE;
                endcase
            end
            S_Q_RD: state_next = S_Q_CHK;
            S_Q_CHK: begin
                if (stat.cmd == CMD_CLOSE || stat.head_expire) begin
                    ctrl.lk_start   = 1'b1;
                    ctrl.key_from_q = 1'b1;
                    state_next      = S_LK_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_LK_RD: state_next = S_LK_CMP;
            S_LK_CMP: begin
                ctrl.lk_cmp = 1'b1;
                if (stat.cmp_hit || stat.cmp_last) begin
                    state_next = S_LK_END;
                end else begin
                    state_next = S_LK_RD;
                end
            end
            S_LK_END: begin
                if (stat.cmd == CMD_ACCEPT) begin
                    ctrl.acc_commit = 1'b1;
                    state_next      = S_DONE;
                end else begin
                    ctrl.ret_commit = 1'b1;
                    if (stat.cmd == CMD_CLOSE) begin
                        state_next = S_Q_WR;
                    end else begin
                        state_next = stat.q_one ? S_DONE : S_Q_RD;
                    end
                end
            end
            S_Q_WR: begin
                ctrl.q_wr  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    ctrl.out_load = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

### sv/pcl_datapath.sv
// datapath: prefix table, closed-connection queue, config registers and result register
// depends on pcl_pkg and pcl_ram
module pcl_datapath #(
    parameter int TABLE_ENTRIES = pcl_pkg::TABLE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH   = pcl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [pcl_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [pcl_pkg::CMD_W-1:0]       s_tuser,
    output logic [pcl_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [pcl_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [pcl_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  pcl_pkg::pcl_ctrl_t              ctrl,
    output pcl_pkg::pcl_stat_t              stat
);
    import pcl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int QA_W  = $clog2(QUEUE_DEPTH);
    localparam int QU_W  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [QA_W-1:0]  QA_LAST  = QA_W'(QUEUE_DEPTH - 1);
    localparam logic [QU_W-1:0]  QU_FULL  = QU_W'(QUEUE_DEPTH);

    // item and config
    cmd_t                cmd_reg;
    logic [PREFIX_W-1:0] prefix_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   win_reg;
    logic [COUNT_W-1:0]  limit_reg;

    // table search state
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]    idx_reg, hit_idx_reg, free_idx_reg;
    logic                hit_reg, free_found_reg;
    logic [COUNT_W-1:0]  hit_cnt_reg;
    logic [PREFIX_W-1:0] key_reg;

    // queue pointers
    logic [QA_W-1:0] head_reg, tail_reg;
    logic [QU_W-1:0] used_reg;

    // result
    logic               acc_reg, tfull_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [EXP_W-1:0]   exp_reg;
    logic [M_TDATA_W-1:0] out_reg;

    // memory ports
    logic [PREFIX_W-1:0] tkey_rd, qkey_rd;
    logic [COUNT_W-1:0]  tcnt_rd;
    logic [TIME_W-1:0]   qtime_rd;
    logic                tkey_we, tcnt_we;
    logic [IDX_W-1:0]    tw_addr;
    logic [COUNT_W-1:0]  tcnt_wdata;

    logic cmp_valid;
    logic admit;

    assign cmp_valid = valid_reg[idx_reg];
    assign admit     = (limit_reg == '0) || (hit_cnt_reg < limit_reg);

    always_comb begin
        stat.cmd         = cmd_reg;
        stat.q_empty     = (used_reg == '0);
        stat.q_full      = (used_reg >= QU_FULL);
        stat.q_one       = (used_reg == QU_W'(1));
        stat.head_expire = ({1'b0, qtime_rd} + {1'b0, win_reg}) < {1'b0, time_reg};
        stat.cmp_hit     = cmp_valid && (tkey_rd == key_reg);
        stat.cmp_last    = (idx_reg == IDX_LAST);
    end

    // table write selection
    always_comb begin
        tkey_we    = 1'b0;
        tcnt_we    = 1'b0;
        tw_addr    = hit_idx_reg;
        tcnt_wdata = hit_cnt_reg;
        if (ctrl.acc_commit) begin
            if (hit_reg) begin
                tcnt_we    = admit;
                tcnt_wdata = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg
                                                        : hit_cnt_reg + COUNT_W'(1);
            end else if (free_found_reg) begin
                tkey_we    = 1'b1;
                tcnt_we    = 1'b1;
                tw_addr    = free_idx_reg;
                tcnt_wdata = COUNT_W'(1);
            end
        end else if (ctrl.ret_commit && hit_reg && hit_cnt_reg > COUNT_W'(1)) begin
            tcnt_we    = 1'b1;
            tcnt_wdata = hit_cnt_reg - COUNT_W'(1);
        end
    end

    pcl_ram #(.WIDTH(PREFIX_W), .DEPTH(TABLE_ENTRIES)) u_tkey (
        .clk(aclk), .we(tkey_we), .waddr(tw_addr), .wdata(key_reg),
        .raddr(idx_reg), .rdata(tkey_rd)
    );
    pcl_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_ENTRIES)) u_tcnt (
        .clk(aclk), .we(tcnt_we), .waddr(tw_addr), .wdata(tcnt_wdata),
        .raddr(idx_reg), .rdata(tcnt_rd)
    );
    pcl_ram #(.WIDTH(PREFIX_W), .DEPTH(QUEUE_DEPTH)) u_qkey (
        .clk(aclk), .we(ctrl.q_wr), .waddr(tail_reg), .wdata(prefix_reg),
        .raddr(head_reg), .rdata(qkey_rd)
    );
    pcl_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_DEPTH)) u_qtime (
        .clk(aclk), .we(ctrl.q_wr), .waddr(tail_reg), .wdata(time_reg),
        .raddr(head_reg), .rdata(qtime_rd)
    );

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            limit_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_SERVICE_WINDOW:   win_reg   <= cfg_wr_data;
                CFG_CONNECTION_LIMIT: limit_reg <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // control state: valid bits and queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            used_reg  <= '0;
        end else begin
            if (ctrl.acc_commit && !hit_reg && free_found_reg) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (ctrl.ret_commit) begin
                head_reg <= (head_reg == QA_LAST) ? '0 : head_reg + QA_W'(1);
                if (hit_reg && hit_cnt_reg <= COUNT_W'(1)) begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
            if (ctrl.q_wr) begin
                tail_reg <= (tail_reg == QA_LAST) ? '0 : tail_reg + QA_W'(1);
            end
            if (ctrl.ret_commit && !ctrl.q_wr) begin
                used_reg <= used_reg - QU_W'(1);
            end else if (ctrl.q_wr && !ctrl.ret_commit) begin
                used_reg <= used_reg + QU_W'(1);
            end
        end
    end

    // item capture, search and result
    always_ff @(posedge aclk) begin
        if (ctrl.load_item) begin
            cmd_reg    <= s_tuser;
            prefix_reg <= s_tdata[PREFIX_W-1:0];
            time_reg   <= s_tdata[PREFIX_W +: TIME_W];
            acc_reg    <= 1'b0;
            tfull_reg  <= 1'b0;
            prio_reg   <= '0;
            exp_reg    <= '0;
        end
        if (ctrl.lk_start) begin
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            key_reg        <= ctrl.key_from_q ? qkey_rd : prefix_reg;
        end
        if (ctrl.lk_cmp) begin
            if (stat.cmp_hit) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx_reg;
                hit_cnt_reg <= tcnt_rd;
            end else begin
                if (!cmp_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= idx_reg;
                end
                if (!stat.cmp_last) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
        if (ctrl.acc_commit) begin
            if (hit_reg) begin
                acc_reg <= admit;
                if (admit && hit_cnt_reg >= PRIORITY_FREE_BELOW) begin
                    prio_reg <= PRIO_W'(0) - {1'b0, hit_cnt_reg};
                end
            end else if (free_found_reg) begin
                acc_reg <= 1'b1;
            end else begin
                tfull_reg <= 1'b1;
            end
        end
        if (ctrl.ret_commit && exp_reg != EXPIRED_MAX) begin
            exp_reg <= exp_reg + EXP_W'(1);
        end
        if (ctrl.out_load) begin
            out_reg <= {4'b0, exp_reg, tfull_reg, prio_reg, acc_reg};
        end
    end

    assign m_tdata = out_reg;
endmodule

### sv/per_prefix_connection_limiter.sv
// Per-prefix connection limiter. Each transaction carries a command in s_tuser (accept,
// close or tick). An accept searches the prefix table one entry at a time, with a read
// step and a compare step per entry, until the prefix is found or the last entry is
// compared. A close is appended to the queue. When the queue is full, the oldest close
// is retired first. That adds a queue read, a head check, one table search and one
// commit step. A tick retires expired closes from the queue head. For every close it
// retires, it adds a queue read, a head check, one table search and one commit step.
// It adds one more queue read and head check when the queue is not emptied and the head
// has to be checked. The table search reads the key memory one address per step. One
// transaction is worked on at a time. A finished result sits in the output register
// while the next transaction is taken. A stalled result holds the block in its last
// step. Configuration writes land at once. They are to be made only while the block is
// idle; the block itself does not enforce this.
// depends on pcl_pkg, pcl_ctrl, pcl_datapath
module per_prefix_connection_limiter #(
    parameter int TABLE_ENTRIES = pcl_pkg::TABLE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH   = pcl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pcl_pkg::S_TDATA_W-1:0]  s_tdata,   // prefix[63:0], event_time[95:64]
    input  logic [pcl_pkg::CMD_W-1:0]      s_tuser,   // command[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pcl_pkg::M_TDATA_W-1:0]  m_tdata,   // accepted[0], priority_res[17:1],
                                                      // table_full[18], expired[27:19]
    input  logic                           cfg_wr_en,
    input  logic [pcl_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [pcl_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import pcl_pkg::*;

    pcl_ctrl_t ctrl;
    pcl_stat_t stat;

    pcl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .stat(stat), .ctrl(ctrl)
    );

    pcl_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .ctrl(ctrl), .stat(stat)
    );
endmodule

### sv/pcl_checker.sv
// port-level checks for the connection limiter, bound to the top level
// depends on per_prefix_connection_limiter
module pcl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // one transaction in flight: input side closes right after a transaction
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a transaction is in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a full table never admits
    a_full_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[18]))
        else $error("admitted and table full together");

    // a priority only comes with an admitted connection
    a_prio_admitted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[17:1] != 17'd0) |-> m_tdata[0])
        else $error("priority on a refused item");
endmodule

bind per_prefix_connection_limiter pcl_checker u_pcl_checker (.*);
